// ===== rtl/core/smx_pkg.sv =====
// ----------------------------------------------------------------------------
// smx_pkg
// Shared constants, opcodes and word types for the stack machine executor.
// ----------------------------------------------------------------------------
package smx_pkg;

	// sizing of the machine
	localparam int STACK_DEPTH  = 256;
	localparam int ADDRESS_BITS = 12;
	localparam int DATA_W       = 32;
	localparam int DEPTH_W      = $clog2(STACK_DEPTH + 1);
	localparam int PTR_W        = $clog2(STACK_DEPTH);
	localparam int OP_W         = 3;

	// fixed widths of the reported fields
	localparam int OUT_ADDR_W  = 12;
	localparam int OUT_DEPTH_W = 9;

	// opcodes; the unused code falls to the no-op arm
	typedef enum logic [OP_W-1:0] {
		OP_PUSH = 3'd0,
		OP_ADD  = 3'd1,
		OP_POP  = 3'd2,
		OP_SET  = 3'd3,
		OP_HALT = 3'd4,
		OP_JUMP = 3'd5,
		OP_NOP  = 3'd6
	} op_t;

	// instruction word
	typedef struct packed {
		logic [OP_W-1:0]          op;
		logic signed [DATA_W-1:0] operand;
	} cmd_t;

	// status word after one instruction
	typedef struct packed {
		logic [OUT_ADDR_W-1:0]    next_address;
		logic signed [DATA_W-1:0] top_value;
		logic signed [DATA_W-1:0] held_a;
		logic [OUT_DEPTH_W-1:0]   stack_depth;
		logic                     halted;
		logic                     fault;
	} rsp_t;

	// stack memory write request
	typedef struct packed {
		logic             en;
		logic [PTR_W-1:0] addr;
		logic [DATA_W-1:0] data;
	} ram_wr_t;

endpackage

// ===== rtl/core/smx_ram.sv =====
// ----------------------------------------------------------------------------
// smx_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module smx_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, data held until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/core/smx_exec.sv =====
// ----------------------------------------------------------------------------
// smx_exec
// Machine state and instruction execute: cached top of stack, depth,
// instruction address, register A and halt flag. Entries below the top
// live in the stack RAM; the second entry arrives from the RAM read.
// ----------------------------------------------------------------------------
module smx_exec
	import smx_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  cmd_t              cmd,
	input  logic [DATA_W-1:0] ram_rdata,
	output logic [PTR_W-1:0]  rd_addr,
	output ram_wr_t           ram_wr,
	output rsp_t              result
);

	logic [DEPTH_W-1:0]      depth_q, depth_d;
	logic [ADDRESS_BITS-1:0] addr_q, addr_d;
	logic [DATA_W-1:0]       tos_q, tos_d;
	logic [DATA_W-1:0]       a_q, a_d;
	logic                    halt_q, halt_d;
	logic                    fault;
	logic                    has1, has2, full;
	logic [PTR_W-1:0]        ptr_top;

	// stack occupancy
	assign has1    = (depth_q != '0);
	assign has2    = (depth_q >= DEPTH_W'(2));
	assign full    = (depth_q == DEPTH_W'(STACK_DEPTH));
	assign ptr_top = PTR_W'(depth_q - DEPTH_W'(1));

	// second entry from the top, fetched when the word is taken
	assign rd_addr = PTR_W'(depth_q - DEPTH_W'(2));

	// execute one instruction
	always_comb begin
		depth_d = depth_q;
		addr_d  = addr_q;
		tos_d   = tos_q;
		a_d     = a_q;
		halt_d  = halt_q;
		fault   = 1'b0;
		ram_wr  = '0;
		if (!halt_q) begin
			addr_d = addr_q + ADDRESS_BITS'(1);
			case (cmd.op)
				OP_PUSH: begin
					addr_d = addr_q + ADDRESS_BITS'(2);
					if (!full) begin
						// spill the old top below the new one
						ram_wr.en   = fire && has1;
						ram_wr.addr = ptr_top;
						ram_wr.data = tos_q;
						tos_d       = cmd.operand;
						depth_d     = depth_q + DEPTH_W'(1);
					end else begin
						fault = 1'b1;
					end
				end
				OP_ADD: begin
					if (has2) begin
						a_d     = tos_q;
						tos_d   = tos_q + ram_rdata;
						depth_d = depth_q - DEPTH_W'(1);
					end else begin
						fault = 1'b1;
					end
				end
				OP_POP: begin
					if (has1) begin
						a_d     = tos_q;
						tos_d   = ram_rdata;
						depth_d = depth_q - DEPTH_W'(1);
					end else begin
						fault = 1'b1;
					end
				end
				OP_HALT: begin
					halt_d = 1'b1;
				end
				OP_JUMP: begin
					addr_d = addr_q + ADDRESS_BITS'(2) + cmd.operand[ADDRESS_BITS-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// status word
	always_comb begin
		result.next_address = OUT_ADDR_W'(addr_d);
		result.top_value    = (depth_d != '0) ? tos_d : '0;
		result.held_a       = a_d;
		result.stack_depth  = OUT_DEPTH_W'(depth_d);
		result.halted       = halt_d;
		result.fault        = fault;
	end

	// control and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= '0;
			addr_q  <= '0;
			a_q     <= '0;
			halt_q  <= 1'b0;
		end else if (fire) begin
			depth_q <= depth_d;
			addr_q  <= addr_d;
			a_q     <= a_d;
			halt_q  <= halt_d;
		end
	end

	// cached top of stack, only read while depth is non-zero
	always_ff @(posedge clk) begin
		if (fire) begin
			tos_q <= tos_d;
		end
	end

endmodule

// ===== rtl/core/stack_machine_executor.sv =====
// ----------------------------------------------------------------------------
// stack_machine_executor
// A word is taken together with its stack RAM read, executes once the output
// register can take it, and its status is then registered and shown on rsp.
// One word is in flight at a time: cmd_stall holds off new words until the
// word in the execute stage, which add and pop feed from the RAM read, executes.
// Reset: arst_n clears depth, address, register A, halt flag and the
// handshake state; the stack RAM is not cleared.
// ----------------------------------------------------------------------------
module stack_machine_executor
	import smx_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	output logic cmd_stall,
	input  cmd_t cmd,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	logic              busy_s1;
	cmd_t              cmd_s1;
	logic              accept;
	logic              fire;
	logic [PTR_W-1:0]  rd_addr;
	logic [DATA_W-1:0] ram_rdata;
	ram_wr_t           ram_wr;
	rsp_t              result;
	rsp_t              rsp_q;
	logic              rsp_valid_q;

	// one word in flight; execute once the output register can take it
	assign cmd_stall = busy_s1;
	assign accept    = cmd_valid && !busy_s1;
	assign fire      = busy_s1 && !(rsp_valid_q && rsp_stall);

	// execute stage occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1 <= 1'b0;
		end else if (accept) begin
			busy_s1 <= 1'b1;
		end else if (fire) begin
			busy_s1 <= 1'b0;
		end
	end

	// captured instruction
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= cmd;
		end
	end

	// stack entries below the top
	smx_ram #(
		.WIDTH(DATA_W),
		.DEPTH(STACK_DEPTH)
	) u_stack (
		.clk  (clk),
		.we   (ram_wr.en),
		.waddr(ram_wr.addr),
		.wdata(ram_wr.data),
		.re   (accept),
		.raddr(rd_addr),
		.rdata(ram_rdata)
	);

	smx_exec u_exec (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (fire),
		.cmd      (cmd_s1),
		.ram_rdata(ram_rdata),
		.rd_addr  (rd_addr),
		.ram_wr   (ram_wr),
		.result   (result)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (fire) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			rsp_q <= result;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef SYNTHESIS
	// halt is sticky from one word to the next
	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && rsp_valid_q && rsp_q.halted) |-> result.halted)
		else $error("halt flag cleared after halt");

	// depth never passes the stack size
	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fire |-> (int'(result.stack_depth) <= STACK_DEPTH))
		else $error("stack depth beyond capacity");

	// an executed word leaves the stage empty and a word on the output
	a_fire_done: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> (!busy_s1 && rsp_valid))
		else $error("executed word not presented");
`endif

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for stack_machine_executor. Instruction words are sent
// in random bursts while the status side stalls on its own pattern. A local
// model of the machine predicts every status word, and each accepted status
// word is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench
	import smx_pkg::*;
();

	localparam int CLK_HALF   = 6;
	localparam int IDLE_LIMIT = 2000;
	localparam int N_RANDOM   = 640;

	// the spare opcode, handled as a no-op
	localparam logic [OP_W-1:0] OP_SPARE = 3'd7;

	// clock, reset and block ports
	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_stall;
	cmd_t cmd       = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	// handshake flags sampled mid-cycle, used by the watchdog
	bit cmd_fire;
	bit rsp_fire;

	// predicted status words, oldest first
	rsp_t pending_status[$];
	int   n_errors   = 0;
	int   burst_left = 0;

	// machine state as the bench sees it
	logic [DATA_W-1:0]       m_stack [STACK_DEPTH];
	int                      m_depth = 0;
	logic [ADDRESS_BITS-1:0] m_addr  = '0;
	logic [DATA_W-1:0]       m_reg_a = '0;
	logic [DATA_W-1:0]       m_reg_b = '0;
	logic [DATA_W-1:0]       m_sum   = '0;
	logic [DATA_W-1:0]       m_jump_ofs = '0;
	logic                    m_halted = 1'b0;

	// receiver stall pattern
	int stall_mode = 0;
	int stall_left = 0;

	stack_machine_executor i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	// run one instruction on the local machine, return the status word
	function automatic rsp_t exec_instr(input logic [OP_W-1:0] op,
			input logic [DATA_W-1:0] operand);
		rsp_t                    st;
		logic                    fault;
		logic [ADDRESS_BITS-1:0] nxt;
		fault = 1'b0;
		if (!m_halted) begin
			nxt = m_addr + ADDRESS_BITS'(1);
			case (op)
				OP_PUSH: begin
					nxt = m_addr + ADDRESS_BITS'(2);
					if (m_depth < STACK_DEPTH) begin
						m_stack[m_depth] = operand;
						m_depth++;
					end else begin
						fault = 1'b1;
					end
				end
				OP_ADD: begin
					if (m_depth >= 2) begin
						m_reg_a = m_stack[m_depth-1];
						m_reg_b = m_stack[m_depth-2];
						m_sum   = m_reg_a + m_reg_b;
						m_stack[m_depth-2] = m_sum;
						m_depth--;
					end else begin
						fault = 1'b1;
					end
				end
				OP_POP: begin
					if (m_depth >= 1) begin
						m_reg_a = m_stack[m_depth-1];
						m_depth--;
					end else begin
						fault = 1'b1;
					end
				end
				OP_HALT: m_halted = 1'b1;
				OP_JUMP: begin
					m_jump_ofs = operand;
					nxt = m_addr + ADDRESS_BITS'(2) + operand[ADDRESS_BITS-1:0];
				end
				default: ;
			endcase
			m_addr = nxt;
		end
		st.next_address = m_addr;
		st.top_value    = (m_depth > 0) ? m_stack[m_depth-1] : '0;
		st.held_a       = m_reg_a;
		st.stack_depth  = m_depth[OUT_DEPTH_W-1:0];
		st.halted       = m_halted;
		st.fault        = fault;
		return st;
	endfunction

	// operand with a bias towards the corners of the range
	function automatic logic [DATA_W-1:0] pick_operand();
		case ($urandom_range(0, 7))
			0:       return 32'h8000_0000;
			1:       return 32'h7fff_ffff;
			2:       return 32'hffff_ffff;
			3:       return '0;
			default: return $urandom();
		endcase
	endfunction

	// jump offsets are mostly short so the address walks about
	function automatic logic [DATA_W-1:0] pick_offset();
		int ofs;
		if ($urandom_range(0, 3) == 0)
			return pick_operand();
		ofs = $urandom_range(0, 80);
		return ofs - 40;
	endfunction

	// send one instruction word, predict its status once accepted
	task automatic issue_instr(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] operand);
		int   gap;
		bit   taken;
		cmd_t w;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				cmd_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		w.op      = op;
		w.operand = operand;
		cmd_valid <= 1'b1;
		cmd       <= w;
		do begin
			@(negedge clk);
			taken = !cmd_stall;
			@(posedge clk);
		end while (!taken);
		pending_status.push_back(exec_instr(op, operand));
	endtask

	task automatic report_diff(input string field, input logic [DATA_W-1:0] want,
			input logic [DATA_W-1:0] got);
		$error("%s: expected 0x%0h, got 0x%0h", field, want, got);
		n_errors++;
	endtask

	// corners: empty-stack faults, wrapping add, every opcode but halt, extreme jumps
	task automatic test_directed();
		issue_instr(OP_NOP,  '0);
		issue_instr(OP_POP,  '0);
		issue_instr(OP_ADD,  '0);
		issue_instr(OP_PUSH, 32'h7fff_ffff);
		issue_instr(OP_ADD,  '0);
		issue_instr(OP_PUSH, 32'h0000_0001);
		issue_instr(OP_ADD,  '0);
		issue_instr(OP_PUSH, 32'h8000_0000);
		issue_instr(OP_PUSH, 32'hffff_ffff);
		issue_instr(OP_ADD,  '0);
		issue_instr(OP_POP,  '0);
		issue_instr(OP_POP,  '0);
		issue_instr(OP_POP,  '0);
		issue_instr(OP_SET,  32'hffff_ffff);
		issue_instr(OP_SPARE, 32'h1234_5678);
		issue_instr(OP_JUMP, '0);
		issue_instr(OP_JUMP, 32'hffff_fffe);
		issue_instr(OP_JUMP, 32'h7fff_ffff);
		issue_instr(OP_JUMP, 32'h8000_0000);
		issue_instr(OP_PUSH, '0);
		issue_instr(OP_POP,  '0);
		issue_instr(OP_NOP,  32'hffff_ffff);
	endtask

	// fill to the brim, overflow, add on a full stack, drain and underflow
	task automatic test_stack_full();
		while (m_depth < STACK_DEPTH)
			issue_instr(OP_PUSH, pick_operand());
		issue_instr(OP_PUSH, pick_operand());
		issue_instr(OP_PUSH, pick_operand());
		issue_instr(OP_ADD,  '0);
		issue_instr(OP_PUSH, pick_operand());
		issue_instr(OP_PUSH, pick_operand());
		while (m_depth > 0)
			issue_instr((m_depth > 1 && $urandom_range(0, 1)) ? OP_ADD : OP_POP, '0);
		issue_instr(OP_POP, '0);
		issue_instr(OP_ADD, '0);
	endtask

	// mostly sensible programmes with random data, some noise, the odd fill
	task automatic test_random_program(input int n_items);
		int                i;
		int                roll;
		bit                filling;
		logic [OP_W-1:0]   op;
		logic [DATA_W-1:0] arg;
		filling = 1'b0;
		for (i = 0; i < n_items; i++) begin
			roll = $urandom_range(0, 99);
			if (!filling && $urandom_range(0, 399) == 0)
				filling = 1'b1;
			if (filling) begin
				op = OP_PUSH;
				if (m_depth == STACK_DEPTH)
					filling = 1'b0;
			end else if (roll < 10) begin
				op = OP_W'($urandom_range(0, (1 << OP_W) - 1));
				if (op == OP_HALT)
					op = OP_NOP;
			end else if (m_depth < 2 && roll < 70) begin
				op = OP_PUSH;
			end else if (roll < 45) begin
				op = OP_PUSH;
			end else if (roll < 70) begin
				op = OP_ADD;
			end else if (roll < 85) begin
				op = OP_POP;
			end else if (roll < 93) begin
				op = OP_JUMP;
			end else if (roll < 96) begin
				op = OP_SET;
			end else begin
				op = OP_NOP;
			end
			arg = (op == OP_JUMP) ? pick_offset() : pick_operand();
			issue_instr(op, arg);
		end
	endtask

	// halt is sticky, so it comes last; every later word must change nothing
	task automatic test_halt();
		int i;
		issue_instr(OP_HALT, pick_operand());
		for (i = 0; i < 24; i++)
			issue_instr(OP_W'($urandom_range(0, (1 << OP_W) - 1)), pick_operand());
	endtask

	// receiver stall pattern: free, light, medium and heavy stretches
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_left = $urandom_range(10, 200);
		end else begin
			stall_left--;
		end
		case (stall_mode)
			0:       rsp_stall <= 1'b0;
			1:       rsp_stall <= ($urandom_range(0, 3) == 0);
			2:       rsp_stall <= ($urandom_range(0, 1) == 1);
			default: rsp_stall <= ($urandom_range(0, 15) < 12);
		endcase
	end

	// status check: payload is stable mid-cycle, ahead of the accepting edge
	always @(negedge clk) begin
		rsp_t want;
		cmd_fire = cmd_valid && !cmd_stall;
		rsp_fire = arst_n && rsp_valid && !rsp_stall;
		if (rsp_fire) begin
			if (pending_status.size() == 0) begin
				$error("status word with no prediction waiting: 0x%0h", rsp);
				n_errors++;
			end else begin
				want = pending_status.pop_front();
				if (rsp.next_address !== want.next_address)
					report_diff("next_address", DATA_W'(want.next_address),
						DATA_W'(rsp.next_address));
				if (rsp.top_value !== want.top_value)
					report_diff("top_value", want.top_value, rsp.top_value);
				if (rsp.held_a !== want.held_a)
					report_diff("held_a", want.held_a, rsp.held_a);
				if (rsp.stack_depth !== want.stack_depth)
					report_diff("stack_depth", DATA_W'(want.stack_depth),
						DATA_W'(rsp.stack_depth));
				if (rsp.halted !== want.halted)
					report_diff("halted", DATA_W'(want.halted), DATA_W'(rsp.halted));
				if (rsp.fault !== want.fault)
					report_diff("fault", DATA_W'(want.fault), DATA_W'(rsp.fault));
			end
		end
	end

	// watchdog on cycles with no word moving on either side
	initial begin
		int idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if (cmd_fire || rsp_fire)
				idle = 0;
			else
				idle++;
		end
		$display("testbench: done, errors");
		$finish;
	end

	// test sequence
	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_stack_full();
		test_random_program(N_RANDOM);
		test_halt();
		cmd_valid <= 1'b0;
		while (pending_status.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		if (n_errors == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule
